@@ sv/hsal_pkg.sv @@
// shared widths, node tables and types for the hermite segment arc length core
// no dependencies
`timescale 1ns / 1ps

package hsal_pkg;

  localparam int DW        = 32;         // input and result width
  localparam int CW        = 37;         // derivative coefficient width, signed
  localparam int IW        = 38;         // inner horner term width, signed
  localparam int DDW       = 39;         // derivative value width
  localparam int SQW       = 80;         // squared length width
  localparam int RW        = SQW / 2;    // length width, one root bit per cell
  localparam int TW        = 30;         // node constant fraction bits
  localparam int HALF_W    = 20;         // split point of the squaring
  localparam int NODES     = 5;
  localparam int AXES      = 3;
  localparam int FRONT_STG = 8;          // coefficient and evaluation stages
  localparam int BACK_STG  = 3;          // weight, sum, result register
  localparam int NSTG      = FRONT_STG + RW + BACK_STG;
  localparam int ACW       = RW + TW + 3; // weighted sum width
  localparam int NODE_RND  = 2 ** (TW - 1);

  localparam logic [TW-1:0] NODE_POS [NODES] = '{
    30'd536870912, 30'd247782408, 30'd825959416, 30'd50369309, 30'd1023372515
  };
  localparam logic [TW-1:0] NODE_WGT [NODES] = '{
    30'd610839805, 30'd513923621, 30'd513923621, 30'd254398300, 30'd254398300
  };

  typedef logic signed [DW-1:0] coord_t;
  typedef logic [SQW-1:0] sq_t;

  typedef struct packed {
    logic ld;   // first stage load
    logic adv;  // remaining stages advance
  } pipe_ctl_t;

  typedef struct packed {
    logic [SQW-1:0] rad;
    logic [RW:0]    rem;
    logic [RW-1:0]  root;
  } sqrt_lane_t;

endpackage

@@ sv/hsal_front.sv @@
// derivative coefficients, horner evaluation at five nodes and squared lengths
// depends on hsal_pkg
`timescale 1ns / 1ps

module hsal_front import hsal_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  coord_t    p0 [AXES],
  input  coord_t    t0 [AXES],
  input  coord_t    p1 [AXES],
  input  coord_t    t1 [AXES],
  output sq_t       sq_o [NODES]
);

  logic signed [CW-1:0] c0_r [AXES], c1_r [AXES], c2_r [AXES];
  logic signed [CW-1:0] c0_nxt [AXES], c1_nxt [AXES], c2_nxt [AXES];
  logic signed [CW-1:0] c0b_r [AXES], c1b_r [AXES], c0c_r [AXES], c0d_r [AXES];
  logic [CW+TW-1:0] p2_r [NODES][AXES], p2_nxt [NODES][AXES];
  logic             n2_r [NODES][AXES];
  logic signed [IW-1:0] inner_r [NODES][AXES], inner_nxt [NODES][AXES];
  logic [IW+TW-1:0] p3_r [NODES][AXES], p3_nxt [NODES][AXES];
  logic             n3_r [NODES][AXES];
  logic [DDW-1:0]   m_r [NODES][AXES], m_nxt [NODES][AXES];
  logic [2*(DDW-HALF_W)-1:0] hh_r [NODES][AXES];
  logic [DDW-1:0]            hl_r [NODES][AXES];
  logic [2*HALF_W-1:0]       ll_r [NODES][AXES];
  sq_t sqa_r [NODES][AXES], sqa_nxt [NODES][AXES];
  sq_t sq_r [NODES];

  // coefficients
  always_comb begin
    logic signed [CW-1:0] dp, tq, tr;
    for (int a = 0; a < AXES; a++) begin
      dp = CW'(p1[a]) - CW'(p0[a]);
      tq = CW'(t0[a]);
      tr = CW'(t1[a]);
      c0_nxt[a] = tq;
      c1_nxt[a] = (dp <<< 2) + (dp <<< 1) - (tq <<< 2) - (tr <<< 1);
      c2_nxt[a] = (tq + tr) + ((tq + tr) <<< 1) - (dp <<< 2) - (dp <<< 1);
    end
  end

  // horner steps, node products rounded half away from zero
  always_comb begin
    logic [CW-1:0]        mag2;
    logic [CW+TW-1:0]     rr2;
    logic signed [IW-1:0] r2s;
    logic [IW-1:0]        mag3;
    logic [IW+TW-1:0]     rr3;
    logic signed [DDW-1:0] r3s, d;
    for (int k = 0; k < NODES; k++) begin
      for (int a = 0; a < AXES; a++) begin
        mag2 = c2_r[a][CW-1] ? CW'(-c2_r[a]) : CW'(c2_r[a]);
        p2_nxt[k][a] = (CW+TW)'(mag2) * (CW+TW)'(NODE_POS[k]);
        rr2 = p2_r[k][a] + (CW+TW)'(NODE_RND);
        r2s = $signed({1'b0, rr2[CW+TW-1:TW]});
        inner_nxt[k][a] = IW'(c1b_r[a]) + (n2_r[k][a] ? -r2s : r2s);
        mag3 = inner_r[k][a][IW-1] ? IW'(-inner_r[k][a]) : IW'(inner_r[k][a]);
        p3_nxt[k][a] = (IW+TW)'(mag3) * (IW+TW)'(NODE_POS[k]);
        rr3 = p3_r[k][a] + (IW+TW)'(NODE_RND);
        r3s = $signed({1'b0, rr3[IW+TW-1:TW]});
        d = DDW'(c0d_r[a]) + (n3_r[k][a] ? -r3s : r3s);
        m_nxt[k][a] = d[DDW-1] ? DDW'(-d) : DDW'(d);
        sqa_nxt[k][a] = (SQW'(hh_r[k][a]) << (2 * HALF_W))
                      + (SQW'(hl_r[k][a]) << (HALF_W + 1))
                      + SQW'(ll_r[k][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
    if (ctl.adv) begin
      c0b_r <= c0_r;
      c1b_r <= c1_r;
      c0c_r <= c0b_r;
      c0d_r <= c0c_r;
      for (int k = 0; k < NODES; k++) begin
        for (int a = 0; a < AXES; a++) begin
          p2_r[k][a]    <= p2_nxt[k][a];
          n2_r[k][a]    <= c2_r[a][CW-1];
          inner_r[k][a] <= inner_nxt[k][a];
          p3_r[k][a]    <= p3_nxt[k][a];
          n3_r[k][a]    <= inner_r[k][a][IW-1];
          m_r[k][a]     <= m_nxt[k][a];
          hh_r[k][a]    <= m_r[k][a][DDW-1:HALF_W] * m_r[k][a][DDW-1:HALF_W];
          hl_r[k][a]    <= m_r[k][a][DDW-1:HALF_W] * m_r[k][a][HALF_W-1:0];
          ll_r[k][a]    <= m_r[k][a][HALF_W-1:0] * m_r[k][a][HALF_W-1:0];
          sqa_r[k][a]   <= sqa_nxt[k][a];
        end
        sq_r[k] <= sqa_r[k][0] + sqa_r[k][1] + sqa_r[k][2];
      end
    end
  end

  assign sq_o = sq_r;

endmodule

@@ sv/hsal_sqrt_cell.sv @@
// one root bit of the floor square root, for all five nodes side by side
// depends on hsal_pkg
`timescale 1ns / 1ps

module hsal_sqrt_cell import hsal_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  sqrt_lane_t lane_i [NODES],
  output sqrt_lane_t lane_o [NODES]
);

  sqrt_lane_t lane_r [NODES], lane_nxt [NODES];

  always_comb begin
    logic [RW+2:0] tmp, trial, diff;
    logic          ge;
    for (int k = 0; k < NODES; k++) begin
      tmp   = {lane_i[k].rem, lane_i[k].rad[SQW-1:SQW-2]};
      trial = {1'b0, lane_i[k].root, 2'b01};
      ge    = tmp >= trial;
      diff  = tmp - trial;
      lane_nxt[k].rem  = ge ? diff[RW:0] : tmp[RW:0];
      lane_nxt[k].root = {lane_i[k].root[RW-2:0], ge};
      lane_nxt[k].rad  = {lane_i[k].rad[SQW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

@@ sv/hermite_segment_arc_length_core.sv @@
// top level of the hermite segment arc length core
// depends on hsal_pkg, hsal_front and hsal_sqrt_cell
`timescale 1ns / 1ps

// Arc length of one 3D cubic Hermite segment by five-point Gauss-Legendre
// quadrature. A request carries both end points and both end tangents in
// signed Q15.16; the result is the length in unsigned Q16.16, clipped to the
// maximum with saturated set when it does not fit. The core is a fixed pipeline
// of 51 stages: eight stages form the derivative coefficients, evaluate the
// derivative at the five nodes and square it, a chain of 40 identical cells
// then forms one root bit each for all five nodes, and three stages weight,
// sum, round and clip. One request enters per cycle while the output is not
// stalled. The whole chain holds while a result is stalled at the output,
// except that an empty first stage still takes a request.

module hermite_segment_arc_length_core import hsal_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_start_z,
  input  coord_t in_start_tan_x,
  input  coord_t in_start_tan_y,
  input  coord_t in_start_tan_z,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  input  coord_t in_end_z,
  input  coord_t in_end_tan_x,
  input  coord_t in_end_tan_y,
  input  coord_t in_end_tan_z,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [DW-1:0]   out_arc_length,
  output logic            out_saturated
);

  // one valid bit per stage, the last is the output register
  logic [NSTG-1:0] v_r, v_nxt;
  pipe_ctl_t ctl;
  logic accept;

  coord_t p0 [AXES], t0 [AXES], p1 [AXES], t1 [AXES];
  sq_t sq [NODES];
  sqrt_lane_t lane [RW+1][NODES];

  logic [RW+TW-1:0] prod_r [NODES];
  logic [ACW-1:0]   sum_r, sum_nxt;
  logic [ACW-1:0]   rnd;
  logic [DW-1:0]    arc_r;
  logic             sat_r;

  // output register full and stalled freezes the chain
  assign ctl.adv = !(v_r[NSTG-1] && out_stall);
  assign ctl.ld  = ctl.adv || !v_r[0];
  assign in_stall = !ctl.adv && v_r[0];
  assign accept   = in_valid && !in_stall;

  always_comb begin
    v_nxt = v_r;
    if (ctl.adv) begin
      v_nxt[NSTG-1:1] = v_r[NSTG-2:0];
    end
    if (ctl.ld) begin
      v_nxt[0] = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign p0 = '{in_start_x, in_start_y, in_start_z};
  assign t0 = '{in_start_tan_x, in_start_tan_y, in_start_tan_z};
  assign p1 = '{in_end_x, in_end_y, in_end_z};
  assign t1 = '{in_end_tan_x, in_end_tan_y, in_end_tan_z};

  hsal_front u_front (
    .clk  (clk),
    .ctl  (ctl),
    .p0   (p0),
    .t0   (t0),
    .p1   (p1),
    .t1   (t1),
    .sq_o (sq)
  );

  // squared lengths enter the root chain with empty remainder and root
  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      lane[0][k].rad  = sq[k];
      lane[0][k].rem  = '0;
      lane[0][k].root = '0;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_cell
    hsal_sqrt_cell u_cell (
      .clk    (clk),
      .en     (ctl.adv),
      .lane_i (lane[j]),
      .lane_o (lane[j+1])
    );
  end

  // weighted sum, halved and rounded, then clipped
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NODES; k++) begin
      sum_nxt = sum_nxt + ACW'(prod_r[k]);
    end
  end

  assign rnd = sum_r + ACW'(2 ** TW);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < NODES; k++) begin
        prod_r[k] <= (RW+TW)'(lane[RW][k].root) * (RW+TW)'(NODE_WGT[k]);
      end
      sum_r <= sum_nxt;
      sat_r <= |rnd[ACW-1:TW+1+DW];
      arc_r <= (|rnd[ACW-1:TW+1+DW]) ? '1 : rnd[TW+DW:TW+1];
    end
  end

  assign out_valid      = v_r[NSTG-1];
  assign out_arc_length = arc_r;
  assign out_saturated  = sat_r;

`ifndef NO_ASSERTIONS
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_arc_length == '1)
    else $error("saturated result not at maximum");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0] && out_valid)
    else $error("input stalled with first stage empty");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.adv |=> $stable(v_r[NSTG-1:1]))
    else $error("pipeline moved while frozen");
`endif

endmodule
